@@ rtl/core/kvt_pkg.sv @@
// Shared types and codes for the keyed value table.
package kvt_pkg;

	// request operation codes
	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_LOOKUP  = 2'd1,
		OP_RLOOKUP = 2'd2,
		OP_REMOVE  = 2'd3
	} op_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// result status codes
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// decisions of the compare unit for one entry read back from the table
	typedef struct packed {
		logic take_entry;
		logic take_free;
	} match_t;

endpackage

@@ rtl/core/kvt_ram.sv @@
// Generic single write port RAM with a registered read port.
module kvt_ram #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write on enable, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/kvt_match.sv @@
// Shared compare unit: judges one table entry against the pending request.
module kvt_match #(
	parameter int KEY_BITS  = 32,
	parameter int DATA_BITS = 32
) (
	input  logic                        pend,
	input  kvt_pkg::op_t                op,
	input  logic                        e_valid,
	input  logic signed [KEY_BITS-1:0]  e_key,
	input  logic        [DATA_BITS-1:0] e_data,
	input  logic signed [KEY_BITS-1:0]  req_key,
	input  logic        [DATA_BITS-1:0] req_data,
	input  logic                        found,
	input  logic signed [KEY_BITS-1:0]  best_key,
	input  logic                        free_found,
	output kvt_pkg::match_t             match
);
	import kvt_pkg::*;

	logic key_eq;
	logic data_eq;
	logic key_gt;

	// one equality pair and one signed magnitude compare
	assign key_eq  = e_valid && (e_key == req_key);
	assign data_eq = e_valid && (e_data == req_data);
	assign key_gt  = e_key > best_key;

	// keep the first key match, or the largest key holding the data; mark the first free slot for an insert
	always_comb begin
		match = '0;
		if (pend) begin
			if (op == OP_RLOOKUP) begin
				match.take_entry = data_eq && (!found || key_gt);
			end else begin
				match.take_entry = key_eq && !found;
			end
			match.take_free = (op == OP_INSERT) && !e_valid && !free_found;
		end
	end

endmodule

@@ rtl/core/keyed_value_table_unit.sv @@
// Top level of the keyed value table: sequencer, table RAM and result register.
//
// Associative table of up to DEPTH entries, each a signed key with a data word,
// keys unique. Requests insert or overwrite, look up by key, look up by data
// (largest signed key holding that data wins) or remove by key; one result beat
// per request. After reset the block sweeps the table RAM to mark every entry
// invalid, and holds req_stall high meanwhile. Each request then passes through
// the accept cycle, one RAM read per entry through the single read port, a drain
// state to compare the last entry, and a write-back state that updates the table
// and loads the result register. A result waiting on rsp_stall does not block the
// next accept, but the write-back of that next request waits for the result
// register to drain.
module keyed_value_table_unit #(
	parameter int DEPTH     = 32,
	parameter int KEY_BITS  = 32,
	parameter int DATA_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  kvt_pkg::op_t                operation,
	input  logic signed [KEY_BITS-1:0]  key_in,
	input  logic        [DATA_BITS-1:0] data_in,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic                        hit,
	output logic                        status,
	output logic signed [KEY_BITS-1:0]  key_out,
	output logic        [DATA_BITS-1:0] data_out
);
	import kvt_pkg::*;

	localparam int ADDR_BITS  = $clog2(DEPTH);
	localparam int CNT_BITS   = $clog2(DEPTH + 1);
	localparam int ENTRY_BITS = 1 + KEY_BITS + DATA_BITS;
	localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);
	localparam logic [CNT_BITS-1:0]  FULL_CNT  = CNT_BITS'(DEPTH);

	state_t state_q, state_d;

	logic [ADDR_BITS-1:0] addr_q;
	logic                 rd_pend_s1;
	logic [ADDR_BITS-1:0] rd_idx_s1;

	op_t                        op_q;
	logic signed [KEY_BITS-1:0] key_q;
	logic [DATA_BITS-1:0]       data_q;

	logic                        found_q;
	logic [ADDR_BITS-1:0]        slot_q;
	logic signed [KEY_BITS-1:0]  mkey_q;
	logic [DATA_BITS-1:0]        mdata_q;
	logic                        free_found_q;
	logic [ADDR_BITS-1:0]        free_slot_q;
	logic [CNT_BITS-1:0]         count_q;

	logic                        rsp_valid_q;
	logic                        hit_q;
	logic                        status_q;
	logic signed [KEY_BITS-1:0]  key_out_q;
	logic [DATA_BITS-1:0]        data_out_q;

	logic                        ram_we;
	logic [ADDR_BITS-1:0]        ram_waddr;
	logic [ENTRY_BITS-1:0]       ram_wdata;
	logic [ENTRY_BITS-1:0]       ram_rdata;

	logic                        e_valid;
	logic signed [KEY_BITS-1:0]  e_key;
	logic [DATA_BITS-1:0]        e_data;
	match_t                      match;

	logic accept;
	logic finish;
	logic ins_new;
	logic ins_full;

	// table storage: {valid, key, data} per entry
	kvt_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	assign e_valid = ram_rdata[ENTRY_BITS-1];
	assign e_key   = ram_rdata[KEY_BITS+DATA_BITS-1:DATA_BITS];
	assign e_data  = ram_rdata[DATA_BITS-1:0];

	kvt_match #(
		.KEY_BITS  (KEY_BITS),
		.DATA_BITS (DATA_BITS)
	) u_match (
		.pend       (rd_pend_s1),
		.op         (op_q),
		.e_valid    (e_valid),
		.e_key      (e_key),
		.e_data     (e_data),
		.req_key    (key_q),
		.req_data   (data_q),
		.found      (found_q),
		.best_key   (mkey_q),
		.free_found (free_found_q),
		.match      (match)
	);

	// classify an insert that found no existing key
	assign ins_new  = (op_q == OP_INSERT) && !found_q && free_found_q && (count_q < FULL_CNT);
	assign ins_full = (op_q == OP_INSERT) && !found_q && !ins_new;

	assign accept = (state_q == ST_IDLE) && req_valid;
	assign finish = (state_q == ST_FINISH) && (!rsp_valid_q || !rsp_stall);

	// next state, input stall and RAM write port
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = addr_q;
				if (addr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (addr_q == LAST_ADDR) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (finish) begin
					state_d = ST_IDLE;
					if (found_q && (op_q == OP_INSERT)) begin
						ram_we    = 1'b1;
						ram_wdata = {1'b1, key_q, data_q};
					end else if (ins_new) begin
						ram_we    = 1'b1;
						ram_waddr = free_slot_q;
						ram_wdata = {1'b1, key_q, data_q};
					end else if (found_q && (op_q == OP_REMOVE)) begin
						ram_we    = 1'b1;
						ram_wdata = '0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// hold state and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			addr_q     <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= (state_q == ST_SCAN);
			if ((state_q == ST_CLEAR) || (state_q == ST_SCAN)) begin
				addr_q <= (addr_q == LAST_ADDR) ? '0 : addr_q + 1'b1;
			end
		end
	end

	// track the read index alongside the RAM latency
	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
	end

	// latch the request beat
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			key_q  <= key_in;
			data_q <= data_in;
		end
	end

	// advance the scan results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (accept) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (match.take_entry) begin
				found_q <= 1'b1;
			end
			if (match.take_free) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (match.take_entry) begin
			slot_q  <= rd_idx_s1;
			mkey_q  <= e_key;
			mdata_q <= e_data;
		end
		if (match.take_free) begin
			free_slot_q <= rd_idx_s1;
		end
	end

	// entry count follows inserts and removes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (finish) begin
			if (ins_new) begin
				count_q <= count_q + 1'b1;
			end else if (found_q && (op_q == OP_REMOVE) && (count_q != '0)) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// result beat: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result beat: payload
	always_ff @(posedge clk) begin
		if (finish) begin
			hit_q    <= found_q;
			status_q <= ins_full ? STATUS_FULL : STATUS_DONE;
			if (!found_q) begin
				key_out_q  <= '0;
				data_out_q <= '0;
			end else if (op_q == OP_INSERT) begin
				key_out_q  <= key_q;
				data_out_q <= data_q;
			end else begin
				key_out_q  <= mkey_q;
				data_out_q <= mdata_q;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign hit       = hit_q;
	assign status    = status_q;
	assign key_out   = key_out_q;
	assign data_out  = data_out_q;

endmodule
